/* sv/bitmap_page_frame_allocator_defines.svh */
// Assertion macros for the bitmap page-frame allocator.
// Used by sv/bitmap_page_frame_allocator.sv; needs a clock and reset in scope.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// condition holds at every edge outside reset
`define BPFA_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define BPFA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bpfa_pkg.sv */
// Shared constants for the bitmap page-frame allocator: field widths,
// operation and status codes, parameter defaults. No dependencies.
package bpfa_pkg;

   localparam int NUM_PAGES_DEF = 65536;
   localparam int MAX_RUN_DEF   = 256;

   localparam int OP_W     = 2;
   localparam int PAGE_W   = 16;
   localparam int CNT_W    = 9;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 64;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

endpackage

/* sv/bitmap_page_frame_allocator.sv */
// Bitmap page-frame allocator: one bit per page in a word memory, a shared
// lowest-set-bit finder and a small sequencer. Depends on bpfa_pkg and the defines header.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_operation, req_page, req_count
//   rsp     | out       | rsp_valid/rsp_stall | rsp_page_res, rsp_status
//
// Reset is synchronous; afterwards a clearing pass writes every bitmap word to all
// used, one word a cycle (1024 words by default) while req_stall is high.
// Each item is taken in idle, checked in dispatch and ends in a result item. Free and
// mark-used read and write back each word of the range; allocation reads the hint word,
// checks the hint page alone for a single page, scans the bitmap word by word, one free or
// used stretch of bits at a time, then reads and writes back each word; all share one port.
// req_stall stays high until the result item is taken; rsp_stall holds the result.
`include "bitmap_page_frame_allocator_defines.svh"

module bitmap_page_frame_allocator
   import bpfa_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   parameter int MAX_RUN   = MAX_RUN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic [CNT_W-1:0]    req_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PAGE_W-1:0]   rsp_page_res,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int BM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WIW      = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
   localparam int WCW      = WIW + 1;
   localparam int PW       = $clog2(NUM_PAGES + 1);
   localparam int AW       = (PW > PAGE_W + 1) ? PW : PAGE_W + 1;
   localparam int RUNW     = CNT_W + 1;

   typedef enum logic [9:0] {
      S_CLR  = 10'b0000000001,
      S_IDLE = 10'b0000000010,
      S_DISP = 10'b0000000100,
      S_ARD  = 10'b0000001000,
      S_HINT = 10'b0000010000,
      S_SRD  = 10'b0000100000,
      S_SCAN = 10'b0001000000,
      S_RRD  = 10'b0010000000,
      S_RWR  = 10'b0100000000,
      S_RESP = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PW-1:0]        hint_ff, hint_in;
   logic [WCW-1:0]       word_ff, word_in;
   logic [6:0]           bit_ff, bit_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [AW-1:0]        first_ff, first_in;
   logic [AW-1:0]        lo_ff, lo_in;
   logic [AW-1:0]        end_ff, end_in;
   logic                 set_ff, set_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;

   logic [WORD_W-1:0]    bitmap_mem_ff [BM_WORDS];
   logic [WORD_W-1:0]    rdata_ff;
   logic                 mem_we;
   logic [WIW-1:0]       mem_addr;
   logic [WORD_W-1:0]    mem_wdata;

   // shared finder and range datapath
   logic                 cur_free;
   logic [WORD_W-1:0]    srch;
   logic [WORD_W-1:0]    iso;
   logic [5:0]           enc;
   logic [6:0]           next_bit;
   logic [6:0]           seg_len;
   logic [RUNW-1:0]      run_sum;
   logic [AW-1:0]        base;
   logic [AW-1:0]        got;
   logic [AW-1:0]        rng_n;
   logic [AW-1:0]        rng_sum;
   logic [AW-1:0]        rng_clip;
   logic [5:0]           lo_bit;
   logic [5:0]           hi_bit;
   logic [WORD_W-1:0]    mask;
   logic [WCW-1:0]       word_next;

   assign mem_addr  = word_ff[WIW-1:0];
   assign word_next = word_ff + WCW'(1);

   always_comb begin
      cur_free = rdata_ff[bit_ff[5:0]];
      srch     = (cur_free ? ~rdata_ff : rdata_ff) & ({WORD_W{1'b1}} << bit_ff[5:0]);
      iso      = srch & (~srch + WORD_W'(1));
      enc      = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (iso[i]) enc = enc | 6'(i);
      end
      next_bit = (srch == '0) ? 7'(WORD_W) : {1'b0, enc};
      seg_len  = next_bit - bit_ff;
      run_sum  = RUNW'(run_ff) + RUNW'(seg_len);
      base     = AW'({word_ff[WIW-1:0], bit_ff[5:0]});
      got      = (run_ff == '0) ? base : first_ff;

      rng_n    = (AW'(count_ff) > AW'(MAX_RUN)) ? AW'(MAX_RUN) : AW'(count_ff);
      rng_sum  = AW'(page_ff) + rng_n;
      rng_clip = (rng_sum > AW'(NUM_PAGES)) ? AW'(NUM_PAGES) : rng_sum;

      lo_bit   = (word_ff == WCW'(lo_ff >> 6)) ? lo_ff[5:0] : 6'd0;
      hi_bit   = (word_ff == WCW'(end_ff >> 6)) ? end_ff[5:0] : 6'd63;
      mask     = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (6'd63 - hi_bit));
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      count_in      = count_ff;
      hint_in       = hint_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      run_in        = run_ff;
      first_in      = first_ff;
      lo_in         = lo_ff;
      end_in        = end_ff;
      set_in        = set_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_wdata     = rdata_ff;

      unique case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (word_ff == WCW'(BM_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               word_in = word_next;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               page_in  = req_page;
               count_in = req_count;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_page_in   = '0;
            res_status_in = ST_OK;
            bit_in        = '0;
            run_in        = '0;
            state_in      = S_RESP;
            if (op_ff == OP_NONE) begin
               res_status_in = ST_OK;
            end else if (count_ff == '0) begin
               res_status_in = ST_ZERO;
            end else if (op_ff == OP_ALLOC) begin
               if (AW'(count_ff) > AW'(MAX_RUN) ||
                   WCW'(hint_ff >> 6) >= WCW'(BM_WORDS)) begin
                  res_status_in = ST_NOSPACE;
               end else begin
                  word_in  = WCW'(hint_ff >> 6);
                  state_in = S_ARD;
               end
            end else begin
               if (op_ff == OP_FREE && AW'(page_ff) < AW'(hint_ff)) begin
                  hint_in = PW'(page_ff);
               end
               if (AW'(page_ff) < AW'(NUM_PAGES)) begin
                  lo_in    = AW'(page_ff);
                  end_in   = rng_clip - AW'(1);
                  word_in  = WCW'(page_ff >> 6);
                  set_in   = (op_ff == OP_FREE);
                  state_in = S_RRD;
               end
            end
         end
         S_ARD: begin
            state_in = (count_ff == CNT_W'(1)) ? S_HINT : S_SCAN;
         end
         S_HINT: begin
            if (AW'(hint_ff) < AW'(NUM_PAGES) && rdata_ff[hint_ff[5:0]]) begin
               lo_in       = AW'(hint_ff);
               end_in      = AW'(hint_ff);
               set_in      = 1'b0;
               res_page_in = PAGE_W'(hint_ff);
               hint_in     = hint_ff + PW'(1);
               state_in    = S_RRD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SRD: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cur_free && run_sum >= RUNW'(count_ff)) begin
               lo_in       = got;
               end_in      = got + AW'(count_ff) - AW'(1);
               word_in     = WCW'(got >> 6);
               set_in      = 1'b0;
               res_page_in = PAGE_W'(got);
               if (count_ff == CNT_W'(1)) begin
                  hint_in = PW'(got + AW'(1));
               end
               state_in = S_RRD;
            end else begin
               if (cur_free) begin
                  run_in = CNT_W'(run_sum);
                  if (run_ff == '0) first_in = base;
               end else begin
                  run_in = '0;
               end
               bit_in = next_bit;
               if (next_bit == 7'(WORD_W)) begin
                  if (word_next == WCW'(BM_WORDS)) begin
                     res_status_in = ST_NOSPACE;
                     state_in      = S_RESP;
                  end else begin
                     word_in  = word_next;
                     bit_in   = '0;
                     state_in = S_SRD;
                  end
               end
            end
         end
         S_RRD: begin
            state_in = S_RWR;
         end
         S_RWR: begin
            mem_we    = 1'b1;
            mem_wdata = set_ff ? (rdata_ff | mask) : (rdata_ff & ~mask);
            if (word_ff == WCW'(end_ff >> 6)) begin
               state_in = S_RESP;
            end else begin
               word_in  = word_next;
               state_in = S_RRD;
            end
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         hint_ff  <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hint_ff  <= hint_in;
         word_ff  <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      page_ff       <= page_in;
      count_ff      <= count_in;
      bit_ff        <= bit_in;
      run_ff        <= run_in;
      first_ff      <= first_in;
      lo_ff         <= lo_in;
      end_ff        <= end_in;
      set_ff        <= set_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) bitmap_mem_ff[mem_addr] <= mem_wdata;
      rdata_ff <= bitmap_mem_ff[mem_addr];
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = (state_ff == S_RESP);
   assign rsp_page_res = res_page_ff;
   assign rsp_status   = res_status_ff;

   `BPFA_ASSERT_HOLDS(a_hint_range, hint_ff <= PW'(NUM_PAGES), "hint beyond page count")
   `BPFA_ASSERT_IMP(a_err_page_zero, rsp_valid && rsp_status != ST_OK, rsp_page_res == '0, "error item carries a page")
   `BPFA_ASSERT_IMP(a_status_code, rsp_valid, rsp_status == ST_OK || rsp_status == ST_NOSPACE || rsp_status == ST_ZERO, "undefined status")
   `BPFA_ASSERT_NEXT(a_accept_dispatch, req_valid && !req_stall, state_ff == S_DISP, "accepted item not dispatched")
   `BPFA_ASSERT_IMP(a_scan_bit, state_ff == S_SCAN, bit_ff < 7'(WORD_W), "scan position past word end")

endmodule
